>>> rtl/hall_tachometer_speed_macros.svh
// ----------------------------------------------------------------------------
// Hall tachometer assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef HALL_TACHOMETER_SPEED_MACROS_SVH
`define HALL_TACHOMETER_SPEED_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define HTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hts_pkg.sv
// ----------------------------------------------------------------------------
// Hall tachometer package
// Shared widths, reset values, register indexes and control structs.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam int TIME_BITS_DEF     = 24;
  localparam int SPEED_BITS_DEF    = 20;
  localparam int MIN_SAMPLE_US_DEF = 20000;
  localparam int STALE_US_DEF      = 500000;

  localparam int COUNT_W    = 32;
  localparam int GLITCH_W   = 9;
  localparam int WHEEL_W    = 20;
  localparam int PPR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 8;

  // circumference in nm = wheel_um * 1000 * pi_q24 >> 24
  localparam int CIRC_A_W = 30;
  localparam int PI_W     = 26;
  localparam int CIRC_P_W = CIRC_A_W + PI_W;
  localparam int CIRC_W   = 32;
  localparam int NUM_W    = 64;

  localparam logic [PI_W-1:0]     PI_Q24      = 26'd52707179;
  localparam logic [9:0]          UM_TO_NM    = 10'd1000;
  localparam logic [GLITCH_W-1:0] GLITCH_MAX  = 9'd500;
  localparam logic [GLITCH_W-1:0] GLITCH_RST  = 9'd35;
  localparam logic [WHEEL_W-1:0]  WHEEL_RST   = 20'd65000;
  localparam logic [PPR_W-1:0]    PPR_RST     = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLITCH = 2'd0,
    CFG_WHEEL  = 2'd1,
    CFG_PPR    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic latch;
    logic tick;
    logic load_raw;
    logic load_inst;
    logic div_start;
    logic filt_sum;
    logic filt_mul;
    logic filt_fix;
    logic out_load;
  } hts_cmd_t;

  typedef struct packed {
    logic raw_go;
    logic inst_ok;
    logic div_busy;
    logic div_done;
    logic out_busy;
  } hts_status_t;

endpackage

>>> rtl/hts_div.sv
// ----------------------------------------------------------------------------
// Hall tachometer divider
// Restoring divider, one quotient bit a cycle, quotient saturated to Q_W bits.
// ----------------------------------------------------------------------------
module hts_div
  import hts_pkg::*;
#(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int Q_W   = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,   // held stable by the caller while busy
  output logic             busy,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int CNT_W = $clog2(Q_W);

  logic [DEN_W-1:0] rem_r;
  logic [Q_W-1:0]   acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic             sat;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // quotient would need more than Q_W bits
  assign sat   = CMP_W'(num[NUM_W-1:Q_W]) >= CMP_W'(den);
  assign trial = {rem_r, acc_r[Q_W-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= ~sat;
        done_r <= sat;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num[NUM_W-1:Q_W]);
      acc_r <= sat ? '1 : num[Q_W-1:0];
      cnt_r <= CNT_W'(Q_W - 1);
    end else if (busy_r) begin
      if (!diff[DEN_W]) begin
        rem_r <= diff[DEN_W-1:0];
      end else begin
        rem_r <= trial[DEN_W-1:0];
      end
      acc_r <= {acc_r[Q_W-2:0], ~diff[DEN_W]};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = acc_r;

endmodule

>>> rtl/hts_datapath.sv
// ----------------------------------------------------------------------------
// Hall tachometer datapath
// Configuration, tick state, operand set-up, filter and result register.
// ----------------------------------------------------------------------------
module hts_datapath
  import hts_pkg::*;
#(
  parameter int TIME_BITS     = TIME_BITS_DEF,
  parameter int SPEED_BITS    = SPEED_BITS_DEF,
  parameter int MIN_SAMPLE_US = MIN_SAMPLE_US_DEF,
  parameter int STALE_US      = STALE_US_DEF,
  parameter int OUT_DATA_W    = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hts_cmd_t              cmd,
  output hts_status_t           status,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int DEN_W = PPR_W + TIME_BITS;
  localparam int FS_W  = SPEED_BITS + 4;
  localparam int K     = FS_W;
  localparam logic [K:0] POW_K = (K+1)'(1) << K;
  localparam logic [SPEED_BITS:0] RECIP10 = (SPEED_BITS+1)'(POW_K / 10);
  localparam int FP_W  = FS_W + SPEED_BITS + 1;
  localparam int FX_W  = SPEED_BITS + 5;

  // configuration
  logic [GLITCH_W-1:0]  glitch_r;
  logic [WHEEL_W-1:0]   wheel_r;
  logic [PPR_W-1:0]     ppr_r;

  // circumference pipeline, follows the wheel register
  logic [CIRC_A_W-1:0]  circ_a_r;
  logic [CIRC_P_W-1:0]  circ_prod;
  logic [CIRC_W-1:0]    circ_r;

  // item
  logic                 lvl_r;
  logic                 qry_r;
  logic                 clr_r;

  // tick state
  logic                 last_level_r;
  logic [COUNT_W-1:0]   pulse_total_r;
  logic [TIME_BITS-1:0] since_pulse_r;
  logic [TIME_BITS-1:0] last_interval_r;
  logic [TIME_BITS-1:0] since_sample_r;
  logic [COUNT_W-1:0]   sample_count_r;
  logic [SPEED_BITS-1:0] smoothed_r;
  logic                 baseline_r;
  logic                 edge_r;
  logic                 raw_go_r;
  logic                 inst_ok_r;

  // divider operands and filter
  logic [NUM_W-1:0]     num_r;
  logic [DEN_W-1:0]     den_r;
  logic [FS_W-1:0]      fsum_r;
  logic [FP_W-1:0]      fprod_r;
  logic                 out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [TIME_BITS-1:0] sp_inc;
  logic [TIME_BITS-1:0] ss_inc;
  logic [GLITCH_W-1:0]  glitch_eff;
  logic                 edge_ok;
  logic [COUNT_W-1:0]   total_new;
  logic                 inst_ok;
  logic                 stale;
  logic                 div_busy;
  logic                 div_done;
  logic [SPEED_BITS-1:0] quot;
  logic [SPEED_BITS:0]  q0;
  logic [FX_W-1:0]      fix_rem;
  logic [SPEED_BITS:0]  q1;
  logic [SPEED_BITS-1:0] filt_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glitch_r <= GLITCH_RST;
      wheel_r  <= WHEEL_RST;
      ppr_r    <= PPR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GLITCH: glitch_r <= cfg_wdata[GLITCH_W-1:0];
        CFG_WHEEL:  wheel_r  <= cfg_wdata[WHEEL_W-1:0];
        CFG_PPR:    ppr_r    <= cfg_wdata[PPR_W-1:0];
        default:    ;
      endcase
    end
  end

  assign circ_prod = CIRC_P_W'(circ_a_r) * CIRC_P_W'(PI_Q24);

  always_ff @(posedge clk) begin
    circ_a_r <= CIRC_A_W'(wheel_r) * CIRC_A_W'(UM_TO_NM);
    circ_r   <= circ_prod[CIRC_P_W-1 -: CIRC_W];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lvl_r <= in_tdata[0];
      qry_r <= in_tdata[1];
      clr_r <= in_tdata[2];
    end
  end

  // saturating timers and glitch clamp
  assign sp_inc = (since_pulse_r == '1) ? since_pulse_r : since_pulse_r + 1'b1;
  assign ss_inc = (since_sample_r == '1) ? since_sample_r : since_sample_r + 1'b1;

  always_comb begin
    priority if (glitch_r == '0) begin
      glitch_eff = GLITCH_W'(1);
    end else if (glitch_r > GLITCH_MAX) begin
      glitch_eff = GLITCH_MAX;
    end else begin
      glitch_eff = glitch_r;
    end
  end

  assign edge_ok   = lvl_r && !last_level_r && (sp_inc >= TIME_BITS'(glitch_eff));
  assign total_new = edge_ok ? pulse_total_r + 1'b1 : pulse_total_r;
  assign inst_ok   = (last_interval_r != '0) && (ppr_r != '0) &&
                     (64'(since_pulse_r) <= 64'(STALE_US));
  assign stale     = 64'(since_pulse_r) > 64'(STALE_US);

  // divide by ten: reciprocal estimate, then one correction step
  assign q0      = fprod_r[K +: SPEED_BITS+1];
  assign fix_rem = FX_W'(fsum_r) - (FX_W'({q0, 3'b000}) + FX_W'({q0, 1'b0}));
  assign q1      = (fix_rem >= FX_W'(10)) ? q0 + 1'b1 : q0;
  assign filt_q  = q1[SPEED_BITS] ? '1 : q1[SPEED_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r    <= 1'b0;
      pulse_total_r   <= '0;
      since_pulse_r   <= '0;
      last_interval_r <= '0;
      since_sample_r  <= '0;
      sample_count_r  <= '0;
      smoothed_r      <= '0;
      baseline_r      <= 1'b0;
      edge_r          <= 1'b0;
      raw_go_r        <= 1'b0;
    end else if (cmd.tick) begin
      last_level_r <= lvl_r;
      edge_r       <= 1'b0;
      raw_go_r     <= 1'b0;
      if (clr_r) begin
        pulse_total_r   <= '0;
        last_interval_r <= '0;
        since_pulse_r   <= '0;
        since_sample_r  <= '0;
        sample_count_r  <= '0;
        smoothed_r      <= '0;
        baseline_r      <= 1'b1;
      end else begin
        pulse_total_r   <= total_new;
        since_pulse_r   <= edge_ok ? '0 : sp_inc;
        since_sample_r  <= ss_inc;
        edge_r          <= edge_ok;
        if (edge_ok) begin
          last_interval_r <= sp_inc;
        end
        if (qry_r) begin
          if (!baseline_r || ppr_r == '0) begin
            // first query, or no magnets set: set the baseline only
            baseline_r     <= 1'b1;
            since_sample_r <= '0;
            sample_count_r <= total_new;
            smoothed_r     <= '0;
          end else if (64'(ss_inc) >= 64'(MIN_SAMPLE_US)) begin
            raw_go_r <= 1'b1;
          end
        end
      end
    end else if (cmd.filt_fix) begin
      smoothed_r     <= stale ? '0 : filt_q;
      since_sample_r <= '0;
      sample_count_r <= pulse_total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_raw) begin
      num_r <= NUM_W'(pulse_total_r - sample_count_r) * NUM_W'(circ_r);
      den_r <= DEN_W'(ppr_r) * DEN_W'(since_sample_r);
    end else if (cmd.load_inst) begin
      num_r <= NUM_W'(circ_r);
      den_r <= DEN_W'(ppr_r) * DEN_W'(last_interval_r);
    end
    if (cmd.load_inst) begin
      inst_ok_r <= inst_ok;
    end
    if (cmd.filt_sum) begin
      fsum_r <= (FS_W'({quot, 3'b000}) - FS_W'(quot)) +
                (FS_W'({smoothed_r, 1'b0}) + FS_W'(smoothed_r));
    end
    if (cmd.filt_mul) begin
      fprod_r <= FP_W'(fsum_r) * FP_W'(RECIP10);
    end
  end

  hts_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (SPEED_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  // result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata_r <= OUT_DATA_W'({edge_r, smoothed_r,
                                  (inst_ok_r ? quot : {SPEED_BITS{1'b0}}),
                                  since_pulse_r, last_interval_r, pulse_total_r});
    end
  end

  assign status.raw_go   = raw_go_r;
  assign status.inst_ok  = inst_ok;
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.out_busy = out_tvalid_r && !out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> rtl/hts_ctrl.sv
// ----------------------------------------------------------------------------
// Hall tachometer controller
// Sequences one tick: state update, averaged speed, instant speed, result.
// ----------------------------------------------------------------------------
`include "hall_tachometer_speed_macros.svh"

module hts_ctrl
  import hts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  hts_status_t status,
  output hts_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_RAW_PREP,
    ST_RAW_START,
    ST_RAW_WAIT,
    ST_FILT_SUM,
    ST_FILT_MUL,
    ST_FILT_FIX,
    ST_INST_PREP,
    ST_INST_START,
    ST_INST_WAIT,
    ST_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.latch = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_TICK;
        end
      end
      ST_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = ST_RAW_PREP;
      end
      ST_RAW_PREP: begin
        cmd.load_raw = status.raw_go;
        state_nxt    = status.raw_go ? ST_RAW_START : ST_INST_PREP;
      end
      ST_RAW_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_RAW_WAIT;
      end
      ST_RAW_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_FILT_SUM;
        end
      end
      ST_FILT_SUM: begin
        cmd.filt_sum = 1'b1;
        state_nxt    = ST_FILT_MUL;
      end
      ST_FILT_MUL: begin
        cmd.filt_mul = 1'b1;
        state_nxt    = ST_FILT_FIX;
      end
      ST_FILT_FIX: begin
        cmd.filt_fix = 1'b1;
        state_nxt    = ST_INST_PREP;
      end
      ST_INST_PREP: begin
        cmd.load_inst = 1'b1;
        // skip the divide when the instant speed reads zero
        state_nxt     = status.inst_ok ? ST_INST_START : ST_OUT;
      end
      ST_INST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_INST_WAIT;
      end
      ST_INST_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.out_load = !status.out_busy;
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  `HTS_ASSERT_NEXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready, "item overlap")
  `HTS_ASSERT_SAME(a_done_in_wait, status.div_done,
    state_r == ST_RAW_WAIT || state_r == ST_INST_WAIT, "divide done outside a wait state")
  `HTS_ASSERT_NEXT(a_div_runs, cmd.div_start, status.div_busy || status.div_done,
    "divider idle after start")

endmodule

>>> rtl/hall_tachometer_speed.sv
// ----------------------------------------------------------------------------
// Hall tachometer speed block
// Each tick runs the state update, the instant divide and the result load; a speed update
// adds the averaged divide and filter, and the instant divide is skipped when none is due.
// One tick at a time: the next is taken once this result is loaded; a stalled result
// adds its wait. Synchronous reset restores the register defaults and clears all counters.
// ----------------------------------------------------------------------------
module hall_tachometer_speed
  import hts_pkg::*;
#(
  parameter int TIME_BITS     = TIME_BITS_DEF,
  parameter int SPEED_BITS    = SPEED_BITS_DEF,
  parameter int MIN_SAMPLE_US = MIN_SAMPLE_US_DEF,
  parameter int STALE_US      = STALE_US_DEF,
  localparam int OUT_FIELDS_W = COUNT_W + 2*TIME_BITS + 2*SPEED_BITS + 1,
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // hall_level, speed_query, clear_all, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pulse_count, pulse_interval_us, since_pulse_us, instant_speed_mm_s,
  // filtered_speed_mm_s, edge_taken, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  hts_cmd_t    cmd;
  hts_status_t status;

  hts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  hts_datapath #(
    .TIME_BITS     (TIME_BITS),
    .SPEED_BITS    (SPEED_BITS),
    .MIN_SAMPLE_US (MIN_SAMPLE_US),
    .STALE_US      (STALE_US),
    .OUT_DATA_W    (OUT_DATA_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Hall tachometer speed testbench
// Streams microsecond ticks through the block under several register settings.
// Every reading is checked against a tachometer model kept in the bench.
// Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb;
  import hts_pkg::*;

  localparam int T_W = TIME_BITS_DEF;
  localparam int S_W = SPEED_BITS_DEF;
  // Shortened windows so that speed updates and stale readings occur within the run
  localparam int SAMPLE_US  = 1000;
  localparam int STALE_LIM  = 1000;
  localparam int DRAIN_CYC  = 64;
  localparam int IDLE_LIMIT = 4000;
  localparam int N_PHASES   = 6;
  localparam int PHASE_TICKS = 330;

  localparam logic [T_W-1:0] T_MAX = '1;
  localparam logic [S_W-1:0] S_MAX = '1;

  // one reading, laid out as in out_tdata (first field in the top bits)
  typedef struct packed {
    logic               edge_hit;
    logic [S_W-1:0]     filt_speed;
    logic [S_W-1:0]     inst_speed;
    logic [T_W-1:0]     since;
    logic [T_W-1:0]     interval;
    logic [COUNT_W-1:0] count;
  } reading_t;

  localparam int RD_W  = $bits(reading_t);
  localparam int OUT_W = ((RD_W + 7) / 8) * 8;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // hall_level, speed_query, clear_all, zero fill
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // pulse_count, pulse_interval_us, since_pulse_us, instant_speed_mm_s,
  // filtered_speed_mm_s, edge_taken, zero fill
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we     = 1'b0;
  cfg_idx_t              cfg_index  = CFG_GLITCH;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // model registers and state
  logic [GLITCH_W-1:0] m_glitch;
  logic [WHEEL_W-1:0]  m_wheel;
  logic [PPR_W-1:0]    m_ppr;
  logic                m_level;
  logic [COUNT_W-1:0]  m_pulses;
  logic [T_W-1:0]      m_since_pulse;
  logic [T_W-1:0]      m_interval;
  logic [T_W-1:0]      m_since_sample;
  logic [COUNT_W-1:0]  m_sample_pulses;
  logic [S_W-1:0]      m_filt;
  logic                m_baseline;

  logic [IN_DATA_W-1:0] ticks_pending[$];
  reading_t             readings_due[$];

  int fail_count  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int ready_left  = 0;
  int stall_left  = 0;
  int query_age   = 0;
  int query_due   = SAMPLE_US;

  hall_tachometer_speed #(
    .MIN_SAMPLE_US(SAMPLE_US),
    .STALE_US     (STALE_LIM)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial forever #4 clk = ~clk;

  function automatic void tach_reset();
    m_glitch        = GLITCH_RST;
    m_wheel         = WHEEL_RST;
    m_ppr           = PPR_RST;
    m_level         = 1'b0;
    m_pulses        = '0;
    m_since_pulse   = '0;
    m_interval      = '0;
    m_since_sample  = '0;
    m_sample_pulses = '0;
    m_filt          = '0;
    m_baseline      = 1'b0;
  endfunction

  function automatic logic [63:0] circumference_nm();
    return (64'(m_wheel) * 64'(UM_TO_NM) * 64'(PI_Q24)) >> 24;
  endfunction

  // floor(a * b / den), saturated to the speed width
  function automatic logic [S_W-1:0] speed_div(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] den);
    logic [127:0] quot;
    if (den == 64'd0) return '0;
    quot = (128'(a) * 128'(b)) / 128'(den);
    return (quot > 128'(S_MAX)) ? S_MAX : quot[S_W-1:0];
  endfunction

  // advance the tachometer by one microsecond tick and form its reading
  function automatic reading_t tach_tick(logic [IN_DATA_W-1:0] d);
    logic                lvl, qry, clr;
    logic [GLITCH_W-1:0] gl;
    logic [COUNT_W-1:0]  delta;
    logic [S_W-1:0]      raw;
    logic [63:0]         mix;
    reading_t            r;
    lvl = d[0];
    qry = d[1];
    clr = d[2];
    r   = '0;
    gl  = (m_glitch == '0) ? GLITCH_W'(1) :
          (m_glitch > GLITCH_MAX) ? GLITCH_MAX : m_glitch;
    if (m_since_pulse != T_MAX) m_since_pulse++;
    if (m_since_sample != T_MAX) m_since_sample++;
    if (clr) begin
      m_pulses        = '0;
      m_interval      = '0;
      m_since_pulse   = '0;
      m_since_sample  = '0;
      m_sample_pulses = '0;
      m_filt          = '0;
      m_baseline      = 1'b1;
    end else begin
      if (lvl && !m_level && m_since_pulse >= T_W'(gl)) begin
        m_pulses++;
        m_interval    = m_since_pulse;
        m_since_pulse = '0;
        r.edge_hit    = 1'b1;
      end
      if (qry) begin
        if (!m_baseline || m_ppr == '0) begin
          m_baseline      = 1'b1;
          m_since_sample  = '0;
          m_sample_pulses = m_pulses;
          m_filt          = '0;
        end else if (m_since_sample >= T_W'(SAMPLE_US)) begin
          delta = m_pulses - m_sample_pulses;
          raw   = speed_div(64'(delta), circumference_nm(),
                            64'(m_ppr) * 64'(m_since_sample));
          mix    = (64'(raw) * 64'd7 + 64'(m_filt) * 64'd3) / 64'd10;
          m_filt = (mix > 64'(S_MAX)) ? S_MAX : mix[S_W-1:0];
          if (m_since_pulse > T_W'(STALE_LIM)) m_filt = '0;
          m_since_sample  = '0;
          m_sample_pulses = m_pulses;
        end
      end
    end
    m_level = lvl;
    if (m_interval != '0 && m_since_pulse <= T_W'(STALE_LIM) && m_ppr != '0)
      r.inst_speed = speed_div(64'd1, circumference_nm(), 64'(m_ppr) * 64'(m_interval));
    r.count      = m_pulses;
    r.interval   = m_interval;
    r.since      = m_since_pulse;
    r.filt_speed = m_filt;
    return r;
  endfunction

  task automatic flag_error(string what);
    $display("[%0t] MISMATCH %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GLITCH: m_glitch = val[GLITCH_W-1:0];
      CFG_WHEEL:  m_wheel  = val[WHEEL_W-1:0];
      CFG_PPR:    m_ppr    = val[PPR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // hold until every tick is taken and every reading is back, then let the block settle
  task automatic drain();
    do @(negedge clk);
    while (ticks_pending.size() != 0 || in_tvalid || readings_due.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic push_tick(logic lvl, logic qry, logic clr);
    ticks_pending.push_back(IN_DATA_W'({clr, qry, lvl}));
    query_age++;
    if (qry) begin
      query_age = 0;
      query_due = SAMPLE_US + $urandom_range(0, 150);
    end
  endtask

  task automatic gen_noise(int n);
    repeat (n)
      push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0,
                $urandom_range(0, 39) == 0);
  endtask

  // pulse trains with bounce, regular speed queries and the odd clear
  task automatic gen_train(int n);
    int  period, high, reps;
    logic lvl, qry;
    while (n > 0) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          period = $urandom_range(2, 12);
          reps   = $urandom_range(1, 6);
        end
        2: begin
          period = STALE_LIM + $urandom_range(50, 400);
          reps   = 1;
        end
        default: begin
          period = $urandom_range(15, 400);
          reps   = $urandom_range(1, 6);
        end
      endcase
      high = $urandom_range(1, period - 1);
      repeat (reps) begin
        for (int k = 0; k < period && n > 0; k++) begin
          lvl = (k < high);
          // one-tick dip on the high level: contact bounce
          if (lvl && k > 0 && $urandom_range(0, 39) == 0) lvl = 1'b0;
          qry = (query_age >= query_due) || ($urandom_range(0, 249) == 0);
          push_tick(lvl, qry, $urandom_range(0, 2499) == 0);
          n--;
        end
      end
    end
  endtask

  task automatic gen_phase(int n);
    int chunk;
    while (n > 0) begin
      chunk = $urandom_range(20, 300);
      if (chunk > n) chunk = n;
      if ($urandom_range(0, 5) == 0) gen_noise(chunk);
      else gen_train(chunk);
      n -= chunk;
    end
  endtask

  always @(posedge clk) begin : tick_driver
    logic                 nxt_valid;
    logic [IN_DATA_W-1:0] nxt_data;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      nxt_data  = in_tdata;
      if (in_tvalid && in_tready) begin
        readings_due.push_back(tach_tick(in_tdata));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (ticks_pending.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data  = ticks_pending.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 100);
          end
        end
      end
      in_tvalid <= nxt_valid;
      in_tdata  <= nxt_data;
    end
  end

  always @(posedge clk) begin : reading_monitor
    reading_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[RD_W-1:0];
        if (readings_due.size() == 0) begin
          flag_error("reading with no tick waiting for it");
        end else begin
          want = readings_due.pop_front();
          check_field("pulse_count", got.count, want.count);
          check_field("pulse_interval_us", 32'(got.interval), 32'(want.interval));
          check_field("since_pulse_us", 32'(got.since), 32'(want.since));
          check_field("instant_speed_mm_s", 32'(got.inst_speed), 32'(want.inst_speed));
          check_field("filtered_speed_mm_s", 32'(got.filt_speed), 32'(want.filt_speed));
          check_field("edge_taken", 32'(got.edge_hit), 32'(want.edge_hit));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (ready_left > 0) begin
          ready_left--;
        end else begin
          ready_left = $urandom_range(0, 300);
          case ($urandom_range(0, 3))
            0:       stall_left = 0;
            1:       stall_left = $urandom_range(1, 3);
            default: stall_left = $urandom_range(1, 120);
          endcase
        end
      end
    end
  end

  // end the run when no transfer has happened for too long
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [GLITCH_W-1:0] gl_val;
    logic [WHEEL_W-1:0]  wheel_val;
    logic [PPR_W-1:0]    ppr_val;
    tach_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero glitch time acts as one tick; widest wheel with one magnet saturates speeds
    cfg_write(CFG_GLITCH, '0);
    cfg_write(CFG_WHEEL, CFG_DATA_W'({WHEEL_W{1'b1}}));
    cfg_write(CFG_PPR, CFG_DATA_W'(1));
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);  // edge at the shortest window
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);  // level held high: no edge
    push_tick(1'b0, 1'b1, 1'b0);  // first query only sets the baseline
    push_tick(1'b1, 1'b1, 1'b0);  // edge with a query inside the sample window
    push_tick(1'b1, 1'b1, 1'b1);  // clear takes the whole tick
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0);  // edge straight after a clear
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b1, 1'b0, 1'b1);  // clear on a rising level: level still tracked
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          gl_val    = GLITCH_RST;
          wheel_val = WHEEL_RST;
          ppr_val   = PPR_RST;
        end
        1: begin
          gl_val    = '0;
          wheel_val = '1;
          ppr_val   = PPR_W'(1);
        end
        2: begin
          gl_val    = GLITCH_MAX;
          wheel_val = '0;
          ppr_val   = '1;
        end
        3: begin
          // glitch beyond the clamp, no magnets: queries only rebase
          gl_val    = '1;
          wheel_val = WHEEL_W'($urandom_range(1, 1048575));
          ppr_val   = '0;
        end
        4: begin
          gl_val    = GLITCH_W'($urandom_range(2, 120));
          wheel_val = WHEEL_W'($urandom_range(0, 1048575));
          ppr_val   = PPR_W'($urandom_range(1, 255));
        end
        default: begin
          gl_val    = GLITCH_W'(1);
          wheel_val = WHEEL_W'($urandom_range(0, 1048575));
          ppr_val   = PPR_W'($urandom_range(1, 16));
        end
      endcase
      cfg_write(CFG_GLITCH, CFG_DATA_W'(gl_val));
      cfg_write(CFG_WHEEL, CFG_DATA_W'(wheel_val));
      cfg_write(CFG_PPR, CFG_DATA_W'(ppr_val));
      gen_phase(PHASE_TICKS);
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
